// ===== sv/ftc_pkg.sv =====
// Shared types, register map and constants for the floor texture cast core.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package ftc_pkg;

	localparam int DIST_W = 25;
	localparam int STORE_AW = 12;

	typedef enum logic [2:0] {
		REG_CANVAS_HEIGHT = 3'd0,
		REG_HORIZON_ROW   = 3'd1,
		REG_PLAYER_X      = 3'd2,
		REG_PLAYER_Y      = 3'd3,
		REG_TEX_WIDTH     = 3'd4,
		REG_TEX_HEIGHT    = 3'd5,
		REG_USE_TEXTURE   = 3'd6,
		REG_FLAT_COLOR    = 3'd7
	} reg_idx_t;

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_PIXEL = 1'b1
	} kind_t;

	localparam logic [9:0] RST_CANVAS_HEIGHT = 10'd480;
	localparam logic [9:0] RST_HORIZON_ROW   = 10'd240;
	localparam logic [6:0] RST_TEX_SIZE      = 7'd64;

	typedef struct packed {
		logic [9:0]  canvas_height;
		logic [9:0]  horizon_row;
		logic [23:0] player_x;
		logic [23:0] player_y;
		logic [6:0]  tex_width;
		logic [6:0]  tex_height;
		logic        use_texture;
		logic [23:0] flat_color;
	} cfg_t;

	typedef struct packed {
		kind_t              kind;
		logic [STORE_AW-1:0] addr;
		logic [23:0]        tcol;
		logic [15:0]        rx;
		logic [15:0]        ry;
		logic               hz;
	} pix_t;

	typedef struct packed {
		logic        res;
		logic        hz;
		logic        bypass;
		logic [23:0] col;
	} shd_meta_t;

	// one restoring step: acc = {remainder[9:0], numerator/quotient[24:0]}
	function automatic logic [DIST_W+9:0] div_step(logic [DIST_W+9:0] acc, logic [9:0] den);
		logic [10:0] hi;
		logic [DIST_W-1:0] lo;
		hi = {acc[DIST_W+9:DIST_W], acc[DIST_W-1]};
		lo = {acc[DIST_W-2:0], 1'b0};
		if (hi >= {1'b0, den}) begin
			hi = hi - {1'b0, den};
			lo[0] = 1'b1;
		end
		return {hi[9:0], lo};
	endfunction

endpackage
`default_nettype wire

// ===== sv/ftc_regs.sv =====
// APB configuration registers of the floor texture cast core.
// Depends on ftc_pkg for the register map and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none
module ftc_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output ftc_pkg::cfg_t    cfg
);

	ftc_pkg::cfg_t    cfg_q;
	ftc_pkg::reg_idx_t idx;
	logic             wr;

	assign idx    = ftc_pkg::reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.canvas_height <= ftc_pkg::RST_CANVAS_HEIGHT;
			cfg_q.horizon_row   <= ftc_pkg::RST_HORIZON_ROW;
			cfg_q.player_x      <= '0;
			cfg_q.player_y      <= '0;
			cfg_q.tex_width     <= ftc_pkg::RST_TEX_SIZE;
			cfg_q.tex_height    <= ftc_pkg::RST_TEX_SIZE;
			cfg_q.use_texture   <= 1'b0;
			cfg_q.flat_color    <= '0;
		end else if (wr) begin
			unique case (idx)
				ftc_pkg::REG_CANVAS_HEIGHT: cfg_q.canvas_height <= pwdata[9:0];
				ftc_pkg::REG_HORIZON_ROW:   cfg_q.horizon_row   <= pwdata[9:0];
				ftc_pkg::REG_PLAYER_X:      cfg_q.player_x      <= pwdata[23:0];
				ftc_pkg::REG_PLAYER_Y:      cfg_q.player_y      <= pwdata[23:0];
				ftc_pkg::REG_TEX_WIDTH:     cfg_q.tex_width     <= pwdata[6:0];
				ftc_pkg::REG_TEX_HEIGHT:    cfg_q.tex_height    <= pwdata[6:0];
				ftc_pkg::REG_USE_TEXTURE:   cfg_q.use_texture   <= pwdata[0];
				ftc_pkg::REG_FLAT_COLOR:    cfg_q.flat_color    <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			ftc_pkg::REG_CANVAS_HEIGHT: prdata = {22'd0, cfg_q.canvas_height};
			ftc_pkg::REG_HORIZON_ROW:   prdata = {22'd0, cfg_q.horizon_row};
			ftc_pkg::REG_PLAYER_X:      prdata = {8'd0, cfg_q.player_x};
			ftc_pkg::REG_PLAYER_Y:      prdata = {8'd0, cfg_q.player_y};
			ftc_pkg::REG_TEX_WIDTH:     prdata = {25'd0, cfg_q.tex_width};
			ftc_pkg::REG_TEX_HEIGHT:    prdata = {25'd0, cfg_q.tex_height};
			ftc_pkg::REG_USE_TEXTURE:   prdata = {31'd0, cfg_q.use_texture};
			ftc_pkg::REG_FLAT_COLOR:    prdata = {8'd0, cfg_q.flat_color};
			default:                    prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/ftc_div.sv =====
// Pipelined restoring divider for the row distance, one quotient bit per stage.
// Depends on ftc_pkg for div_step and the pix_t payload carried alongside.
`timescale 1ns / 1ps
`default_nettype none
module ftc_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       vld_in,
	input  wire ftc_pkg::pix_t              pix_in,
	input  wire logic [ftc_pkg::DIST_W-1:0] num,
	input  wire logic [9:0]                 den,
	output logic                            vld_out,
	output ftc_pkg::pix_t                   pix_out,
	output logic [ftc_pkg::DIST_W-1:0]      quo
);

	localparam int N = ftc_pkg::DIST_W;

	logic [N-1:0]   vld_s;
	logic [N+9:0]   acc_s [N];
	logic [9:0]     den_s [N];
	ftc_pkg::pix_t  pix_s [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N-2:0], vld_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s[0] <= ftc_pkg::div_step({10'd0, num}, den);
			den_s[0] <= den;
			pix_s[0] <= pix_in;
			for (int k = 1; k < N; k++) begin
				acc_s[k] <= ftc_pkg::div_step(acc_s[k-1], den_s[k-1]);
				den_s[k] <= den_s[k-1];
				pix_s[k] <= pix_s[k-1];
			end
		end
	end

	assign vld_out = vld_s[N-1];
	assign pix_out = pix_s[N-1];
	assign quo     = acc_s[N-1][N-1:0];

endmodule
`default_nettype wire

// ===== sv/ftc_shade.sv =====
// Distance shading: pipelined restoring division of each RGB channel by the
// shade factor, one quotient bit per stage. Depends on ftc_pkg for shd_meta_t.
`timescale 1ns / 1ps
`default_nettype none
module ftc_shade #(
	parameter int SW = 31
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               vld_in,
	input  wire ftc_pkg::shd_meta_t meta_in,
	input  wire logic [SW-1:0]      s_in,
	output logic                    vld_out,
	output logic                    res_out,
	output logic                    hz_out,
	output logic [23:0]             color_out
);

	localparam int NST = 8;
	localparam int CW = SW + 8;

	logic [NST-1:0]     vld_s;
	logic [31:0]        rem_s [NST][3];
	logic [7:0]         q_s   [NST][3];
	logic [SW-1:0]      sd_s  [NST];
	ftc_pkg::shd_meta_t meta_s [NST];
	logic [31:0]        rem_n [NST][3];
	logic [7:0]         q_n   [NST][3];

	always_comb begin
		logic [31:0]   r;
		logic [7:0]    qv;
		logic [SW-1:0] sv;
		logic [CW-1:0] d;
		for (int k = 0; k < NST; k++) begin
			for (int c = 0; c < 3; c++) begin
				if (k == 0) begin
					r  = {meta_in.col[23-8*c -: 8], 24'd0};
					qv = '0;
					sv = s_in;
				end else begin
					r  = rem_s[k-1][c];
					qv = q_s[k-1][c];
					sv = sd_s[k-1];
				end
				d = CW'(sv) << (NST - 1 - k);
				if (CW'(r) >= d) begin
					r = 32'(CW'(r) - d);
					qv[NST-1-k] = 1'b1;
				end
				rem_n[k][c] = r;
				q_n[k][c]   = qv;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-2:0], vld_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s[0]   <= s_in;
			meta_s[0] <= meta_in;
			for (int k = 1; k < NST; k++) begin
				sd_s[k]   <= sd_s[k-1];
				meta_s[k] <= meta_s[k-1];
			end
			for (int k = 0; k < NST; k++) begin
				for (int c = 0; c < 3; c++) begin
					rem_s[k][c] <= rem_n[k][c];
					q_s[k][c]   <= q_n[k][c];
				end
			end
		end
	end

	assign vld_out = vld_s[NST-1];
	assign res_out = meta_s[NST-1].res;
	assign hz_out  = meta_s[NST-1].hz;

	always_comb begin
		if (meta_s[NST-1].hz) begin
			color_out = '0;
		end else if (meta_s[NST-1].bypass) begin
			color_out = meta_s[NST-1].col;
		end else begin
			color_out = {q_s[NST-1][0], q_s[NST-1][1], q_s[NST-1][2]};
		end
	end

endmodule
`default_nettype wire

// ===== sv/floor_texture_cast_core.sv =====
// Channel   | Dir | Payload
// s_axis    | in  | tdata: texel_addr, texel_color, ray_x, ray_y, pixel_row; tuser: kind
// m_axis    | out | tdata: color; tuser: on_horizon
// apb       | in  | eight registers at byte address 4*i
// One item enters per clock while s_tready is high. Each item passes the input register,
// 25 stages of the row distance divider (one quotient bit each), multiply, texel
// coordinate, texture memory, 8 stages of the shading divider and the output register.
// arst_n clears all valid bits and the configuration registers; the texture memory has no reset.
// The pipeline stalls only when a result waits at the output and another is behind it.
// Floor texture cast top level: input stage, distance and texel address stages,
// texture memory, shading, output register. Uses ftc_pkg, ftc_regs, ftc_div, ftc_shade.
`timescale 1ns / 1ps
`default_nettype none
module floor_texture_cast_core #(
	parameter int TEX_SIDE = 64,
	parameter int SHADE_Q8 = 51
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,  // texel_addr, texel_color, ray_x, ray_y, pixel_row, pad
	input  wire logic        s_tuser,  // kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // color
	output logic             m_tuser,  // on_horizon
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int SW = ftc_pkg::DIST_W + $clog2(SHADE_Q8 + 1);
	localparam int AW = 8 + $clog2(TEX_SIDE + 1);
	localparam int DW = ftc_pkg::DIST_W;

	ftc_pkg::cfg_t cfg;
	logic          adv;

	ftc_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	// stage 1: input register
	logic          vld_s1;
	ftc_pkg::pix_t pix_s1;
	logic [9:0]    row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1.kind <= ftc_pkg::kind_t'(s_tuser);
			pix_s1.addr <= s_tdata[11:0];
			pix_s1.tcol <= s_tdata[35:12];
			pix_s1.rx   <= s_tdata[51:36];
			pix_s1.ry   <= s_tdata[67:52];
			pix_s1.hz   <= 1'b0;
			row_s1      <= s_tdata[77:68];
		end
	end

	logic [9:0]    diff;
	ftc_pkg::pix_t pix_dv;

	always_comb begin
		diff = (row_s1 > cfg.horizon_row) ? row_s1 - cfg.horizon_row
		                                  : cfg.horizon_row - row_s1;
		pix_dv    = pix_s1;
		pix_dv.hz = (row_s1 == cfg.horizon_row);
	end

	logic          vld_d;
	ftc_pkg::pix_t pix_d;
	logic [DW-1:0] row_dist;

	ftc_div u_div (
		.clk(clk), .arst_n(arst_n), .en(adv), .vld_in(vld_s1), .pix_in(pix_dv),
		.num({cfg.canvas_height, 15'd0}), .den(diff),
		.vld_out(vld_d), .pix_out(pix_d), .quo(row_dist)
	);

	// stage 2: map offsets and shade factor
	logic          vld_s2;
	ftc_pkg::pix_t pix_s2;
	logic [29:0]   px_s2;
	logic [29:0]   py_s2;
	logic [SW-1:0] s_s2;
	logic [41:0]   prod_x;
	logic [41:0]   prod_y;

	assign prod_x = $signed(pix_d.rx) * $signed({1'b0, row_dist});
	assign prod_y = $signed(pix_d.ry) * $signed({1'b0, row_dist});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s2 <= pix_d;
			px_s2  <= prod_x[29:0];
			py_s2  <= prod_y[29:0];
			s_s2   <= SW'(row_dist) * SW'(SHADE_Q8);
		end
	end

	// stage 3: texel coordinates
	logic          vld_s3;
	ftc_pkg::pix_t pix_s3;
	logic [SW-1:0] s_s3;
	logic [6:0]    tx_s3;
	logic [6:0]    ty_s3;
	logic [29:0]   npy;
	logic [15:0]   fx;
	logic [15:0]   fy;
	logic [22:0]   mx;
	logic [22:0]   my;

	always_comb begin
		npy = 30'd0 - py_s2;
		fx  = cfg.player_x[15:0] + px_s2[29:14];
		fy  = cfg.player_y[15:0] + npy[29:14];
		mx  = 23'(fx) * 23'(cfg.tex_width);
		my  = 23'(fy) * 23'(cfg.tex_height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s3 <= pix_s2;
			s_s3   <= s_s2;
			tx_s3  <= mx[22:16];
			ty_s3  <= my[22:16];
		end
	end

	// stage 4: texture memory, loads write here to keep item order
	logic [23:0]   tex_mem [1 << ftc_pkg::STORE_AW];
	logic          vld_s4;
	ftc_pkg::pix_t pix_s4;
	logic [SW-1:0] s_s4;
	logic [23:0]   rdata_s4;
	logic [AW-1:0] addr_full;
	logic          ld;

	assign addr_full = AW'(ty_s3) * AW'(TEX_SIDE) + AW'(tx_s3);
	assign ld        = vld_s3 && (pix_s3.kind == ftc_pkg::KIND_LOAD);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ld) begin
				tex_mem[pix_s3.addr] <= pix_s3.tcol;
			end
			rdata_s4 <= tex_mem[addr_full[ftc_pkg::STORE_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s4 <= pix_s3;
			s_s4   <= s_s3;
		end
	end

	ftc_pkg::shd_meta_t meta;

	always_comb begin
		meta.res    = (pix_s4.kind == ftc_pkg::KIND_PIXEL);
		meta.hz     = pix_s4.hz;
		meta.bypass = (s_s4[SW-1:24] == '0);
		meta.col    = cfg.use_texture ? rdata_s4 : cfg.flat_color;
	end

	logic        vld_o;
	logic        res_o;
	logic        hz_o;
	logic [23:0] col_o;

	ftc_shade #(.SW(SW)) u_shade (
		.clk(clk), .arst_n(arst_n), .en(adv), .vld_in(vld_s4), .meta_in(meta), .s_in(s_s4),
		.vld_out(vld_o), .res_out(res_o), .hz_out(hz_o), .color_out(col_o)
	);

	// output register
	logic        out_vld_q;
	logic [23:0] out_col_q;
	logic        out_hz_q;
	logic        last_res;
	logic        out_free;

	assign last_res = vld_o && res_o;
	assign out_free = !out_vld_q || m_tready;
	assign adv      = out_free || !last_res;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= last_res;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && last_res) begin
			out_col_q <= col_o;
			out_hz_q  <= hz_o;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_col_q;
	assign m_tuser  = out_hz_q;

endmodule
`default_nettype wire
